// ===== rtl/core/bht_pkg.sv =====
// Shared constants for the bucket hash table: field widths, operation and
// status codes, default parameter values. No dependencies.
package bht_pkg;

   localparam int SLOTS_PER_BLOCK_DEF = 8;
   localparam int POOL_BLOCKS_DEF     = 256;
   localparam int MAX_BUCKETS_DEF     = 64;

   localparam int OP_W   = 2;
   localparam int KEY_W  = 31;
   localparam int DATA_W = 64;
   localparam int ST_W   = 2;
   localparam int IDX_W  = 9;
   localparam int NB_W   = 7;

   localparam int RESET_BUCKETS = 16;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
   localparam logic [ST_W-1:0] ST_DUPLICATE = 2'd1;
   localparam logic [ST_W-1:0] ST_POOL_FULL = 2'd2;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

// ===== rtl/core/bht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/bht_mod.sv =====
// Bit-serial remainder unit: key modulo bucket count, one key bit a cycle.
// Depends on bht_pkg.
module bht_mod (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bht_pkg::KEY_W-1:0]  dividend,
   input  logic [bht_pkg::NB_W-1:0]   divisor,
   output logic                       done,
   output logic [bht_pkg::NB_W-1:0]   remainder
);
   import bht_pkg::*;

   localparam int CW = $clog2(KEY_W + 1);

   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [KEY_W-1:0] sh_ff, sh_in;
   logic [NB_W-1:0]  rem_ff, rem_in;
   logic [NB_W:0]    trial;

   always_comb begin
      trial   = {rem_ff, sh_ff[KEY_W-1]};
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sh_in   = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         // restoring step: subtract when the partial remainder allows
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
         end
         rem_in = trial[NB_W-1:0];
         sh_in  = {sh_ff[KEY_W-2:0], 1'b0};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(KEY_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/bucket_hash_table_overflow_chain_top.sv =====
// Top level of the bucket hash table: sequencer, block metadata and slot RAMs.
// Depends on bht_pkg, bht_ram and bht_mod.
//
// Keyed record store. Each request (req_) inserts, looks up or deletes one
// record by key; each request yields exactly one response (rsp_). Both
// channels use valid/ready; a transfer happens when both are high.
// The bucket is key modulo the bucket count, computed serially in 31
// steps, one key bit per step, before the remainder is handed over.
// The chain of the bucket is then walked: per block, a metadata read
// (S_MRD, S_MWT) and the end-of-block check (S_SRD); per slot, the slot RAM
// read (S_SRD) and, for an occupied slot only, the key compare (S_SCMP).
// A new block at the chain end adds the S_WR2 metadata write; an unknown
// operation skips hashing and answers directly. One request is in work at
// a time; req_ready is low while it runs and rises together with rsp_valid
// when the response is loaded. A finished response sits in an output
// register, so the next request is taken while the receiver stalls; the
// sequencer holds a further response until the output register is free.
// Reset (synchronous) and every csr_we write clear the store at once
// through per-block valid bits; csr_we sets the bucket count (clamped to
// 1 .. min(MAX_BUCKETS, POOL_BLOCKS, 127)) and may only be used while idle.
module bucket_hash_table_overflow_chain_top #(
   parameter int SLOTS_PER_BLOCK = bht_pkg::SLOTS_PER_BLOCK_DEF,
   parameter int POOL_BLOCKS     = bht_pkg::POOL_BLOCKS_DEF,
   parameter int MAX_BUCKETS     = bht_pkg::MAX_BUCKETS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [bht_pkg::OP_W-1:0]   req_operation,
   input  logic [bht_pkg::KEY_W-1:0]  req_key,
   input  logic [bht_pkg::DATA_W-1:0] req_entry_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [bht_pkg::ST_W-1:0]   rsp_status,
   output logic [bht_pkg::IDX_W-1:0]  rsp_block_index,
   output logic [bht_pkg::IDX_W-1:0]  rsp_chain_position,
   output logic [bht_pkg::DATA_W-1:0] rsp_found_data,
   input  logic                       csr_we,
   input  logic [bht_pkg::NB_W-1:0]   csr_wdata
);
   import bht_pkg::*;

   localparam int BW   = $clog2(POOL_BLOCKS);
   localparam int LW   = $clog2(POOL_BLOCKS + 1);
   localparam int SW   = (SLOTS_PER_BLOCK > 1) ? $clog2(SLOTS_PER_BLOCK) : 1;
   localparam int SCW  = $clog2(SLOTS_PER_BLOCK + 1);
   localparam int SAW  = $clog2(POOL_BLOCKS * SLOTS_PER_BLOCK);
   localparam int MW   = LW + SLOTS_PER_BLOCK;
   localparam int SDW  = KEY_W + DATA_W;
   localparam int CAP0 = (MAX_BUCKETS < POOL_BLOCKS) ? MAX_BUCKETS : POOL_BLOCKS;
   localparam int CAP  = (CAP0 < 127) ? CAP0 : 127;
   localparam int RST_NB = (RESET_BUCKETS > CAP) ? CAP : RESET_BUCKETS;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_MOD  = 9'b000000010,
      S_MRD  = 9'b000000100,
      S_MWT  = 9'b000001000,
      S_SRD  = 9'b000010000,
      S_SCMP = 9'b000100000,
      S_WR2  = 9'b001000000,
      S_RESP = 9'b010000000,
      S_SPARE = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [NB_W-1:0]   nb_ff, nb_in;
   logic [LW-1:0]     alloc_ff, alloc_in;
   logic [POOL_BLOCKS-1:0] valid_ff, valid_in;

   logic [OP_W-1:0]   op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [DATA_W-1:0] data_ff, data_in;

   logic [BW-1:0]     blk_ff, blk_in;
   logic [LW-1:0]     pos_ff, pos_in;
   logic [SCW-1:0]    scnt_ff, scnt_in;
   logic [SLOTS_PER_BLOCK-1:0] used_ff, used_in;
   logic [LW-1:0]     link_ff, link_in;

   logic              have_free_ff, have_free_in;
   logic [BW-1:0]     ins_blk_ff, ins_blk_in;
   logic [SW-1:0]     ins_slot_ff, ins_slot_in;
   logic [SLOTS_PER_BLOCK-1:0] ins_used_ff, ins_used_in;
   logic [LW-1:0]     ins_link_ff, ins_link_in;

   logic [ST_W-1:0]   res_st_ff, res_st_in;
   logic [IDX_W-1:0]  res_bidx_ff, res_bidx_in;
   logic [IDX_W-1:0]  res_cpos_ff, res_cpos_in;
   logic [DATA_W-1:0] res_data_ff, res_data_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ST_W-1:0]   rsp_st_ff, rsp_st_in;
   logic [IDX_W-1:0]  rsp_bidx_ff, rsp_bidx_in;
   logic [IDX_W-1:0]  rsp_cpos_ff, rsp_cpos_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic              m_we, s_we;
   logic [BW-1:0]     m_waddr, m_raddr;
   logic [MW-1:0]     m_wdata, m_rdata;
   logic [SAW-1:0]    s_waddr, s_raddr;
   logic [SDW-1:0]    s_wdata, s_rdata;

   logic              mod_start, mod_done;
   logic [NB_W-1:0]   mod_rem;

   logic              accept;
   logic [SLOTS_PER_BLOCK-1:0] cur_used;
   logic [LW-1:0]     cur_link;
   logic [SW-1:0]     first_free;
   logic [SW-1:0]     sidx;
   logic              chain_end;

   bht_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (key_in),
      .divisor   (nb_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   bht_ram #(.WIDTH(MW), .DEPTH(POOL_BLOCKS)) u_meta (
      .clock (clock),
      .we    (m_we),
      .waddr (m_waddr),
      .wdata (m_wdata),
      .raddr (m_raddr),
      .rdata (m_rdata)
   );

   bht_ram #(.WIDTH(SDW), .DEPTH(POOL_BLOCKS * SLOTS_PER_BLOCK)) u_slot (
      .clock (clock),
      .we    (s_we),
      .waddr (s_waddr),
      .wdata (s_wdata),
      .raddr (s_raddr),
      .rdata (s_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign mod_start = accept && (req_operation inside {OP_INSERT, OP_LOOKUP, OP_DELETE});
   assign sidx      = scnt_ff[SW-1:0];

   // a block never written since the last clear reads as empty, end of chain
   assign cur_used = valid_ff[blk_ff] ? m_rdata[SLOTS_PER_BLOCK-1:0] : '0;
   assign cur_link = valid_ff[blk_ff] ? m_rdata[MW-1:SLOTS_PER_BLOCK] : '0;
   assign chain_end = (link_ff == '0) || (link_ff > LW'(POOL_BLOCKS));

   always_comb begin
      first_free = '0;
      for (int i = SLOTS_PER_BLOCK - 1; i >= 0; i--) begin
         if (!cur_used[i]) begin
            first_free = SW'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      nb_in        = nb_ff;
      alloc_in     = alloc_ff;
      valid_in     = valid_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      data_in      = data_ff;
      blk_in       = blk_ff;
      pos_in       = pos_ff;
      scnt_in      = scnt_ff;
      used_in      = used_ff;
      link_in      = link_ff;
      have_free_in = have_free_ff;
      ins_blk_in   = ins_blk_ff;
      ins_slot_in  = ins_slot_ff;
      ins_used_in  = ins_used_ff;
      ins_link_in  = ins_link_ff;
      res_st_in    = res_st_ff;
      res_bidx_in  = res_bidx_ff;
      res_cpos_in  = res_cpos_ff;
      res_data_in  = res_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_st_in    = rsp_st_ff;
      rsp_bidx_in  = rsp_bidx_ff;
      rsp_cpos_in  = rsp_cpos_ff;
      rsp_data_in  = rsp_data_ff;
      m_we    = 1'b0;
      m_waddr = blk_ff;
      m_wdata = {link_ff, used_ff};
      m_raddr = blk_ff;
      s_we    = 1'b0;
      s_waddr = SAW'(ins_blk_ff) * SAW'(SLOTS_PER_BLOCK) + SAW'(ins_slot_ff);
      s_wdata = {key_ff, data_ff};
      s_raddr = SAW'(blk_ff) * SAW'(SLOTS_PER_BLOCK) + SAW'(sidx);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in       = req_operation;
               key_in      = req_key;
               data_in     = req_entry_data;
               res_st_in   = ST_NOT_FOUND;
               res_bidx_in = '0;
               res_cpos_in = '0;
               res_data_in = '0;
               state_in    = mod_start ? S_MOD : S_RESP;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               blk_in       = BW'(mod_rem);
               pos_in       = LW'(1);
               have_free_in = 1'b0;
               state_in     = S_MRD;
            end
         end
         S_MRD: begin
            state_in = S_MWT;
         end
         S_MWT: begin
            used_in = cur_used;
            link_in = cur_link;
            scnt_in = '0;
            // remember the first block in the chain with a free slot
            if (!have_free_ff && !(&cur_used)) begin
               have_free_in = 1'b1;
               ins_blk_in   = blk_ff;
               ins_slot_in  = first_free;
               ins_used_in  = cur_used;
               ins_link_in  = cur_link;
            end
            state_in = S_SRD;
         end
         S_SRD: begin
            if (scnt_ff == SCW'(SLOTS_PER_BLOCK)) begin
               if (!chain_end) begin
                  blk_in   = BW'(link_ff - LW'(1));
                  pos_in   = pos_ff + LW'(1);
                  state_in = S_MRD;
               end else if (op_ff != OP_INSERT) begin
                  state_in = S_RESP;
               end else if (have_free_ff) begin
                  s_we    = 1'b1;
                  m_we    = 1'b1;
                  m_waddr = ins_blk_ff;
                  m_wdata = {ins_link_ff,
                             ins_used_ff | (SLOTS_PER_BLOCK'(1) << ins_slot_ff)};
                  valid_in[ins_blk_ff] = 1'b1;
                  res_st_in   = ST_DONE;
                  res_bidx_in = IDX_W'(LW'(ins_blk_ff) + LW'(1));
                  state_in    = S_RESP;
               end else if (alloc_ff >= LW'(POOL_BLOCKS)) begin
                  res_st_in = ST_POOL_FULL;
                  state_in  = S_RESP;
               end else begin
                  // link a fresh block after the tail, store in its first slot
                  m_we    = 1'b1;
                  m_waddr = blk_ff;
                  m_wdata = {alloc_ff + LW'(1), used_ff};
                  valid_in[blk_ff] = 1'b1;
                  s_we    = 1'b1;
                  s_waddr = SAW'(alloc_ff) * SAW'(SLOTS_PER_BLOCK);
                  state_in = S_WR2;
               end
            end else if (used_ff[sidx]) begin
               state_in = S_SCMP;
            end else begin
               scnt_in = scnt_ff + SCW'(1);
            end
         end
         S_SCMP: begin
            if (s_rdata[SDW-1:DATA_W] == key_ff) begin
               state_in = S_RESP;
               case (op_ff)
                  OP_INSERT: begin
                     res_st_in = ST_DUPLICATE;
                  end
                  OP_LOOKUP: begin
                     res_st_in   = ST_DONE;
                     res_cpos_in = IDX_W'(pos_ff);
                     res_data_in = s_rdata[DATA_W-1:0];
                  end
                  default: begin
                     m_we      = 1'b1;
                     m_wdata   = {link_ff, used_ff & ~(SLOTS_PER_BLOCK'(1) << sidx)};
                     valid_in[blk_ff] = 1'b1;
                     res_st_in = ST_DONE;
                  end
               endcase
            end else begin
               scnt_in  = scnt_ff + SCW'(1);
               state_in = S_SRD;
            end
         end
         S_WR2: begin
            m_we    = 1'b1;
            m_waddr = BW'(alloc_ff);
            m_wdata = {LW'(0), SLOTS_PER_BLOCK'(1)};
            valid_in[BW'(alloc_ff)] = 1'b1;
            alloc_in    = alloc_ff + LW'(1);
            res_st_in   = ST_DONE;
            res_bidx_in = IDX_W'(alloc_ff + LW'(1));
            state_in    = S_RESP;
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = res_st_ff;
               rsp_bidx_in  = res_bidx_ff;
               rsp_cpos_in  = res_cpos_ff;
               rsp_data_in  = res_data_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_we) begin
         if (csr_wdata == '0) begin
            nb_in = NB_W'(1);
         end else if (csr_wdata > NB_W'(CAP)) begin
            nb_in = NB_W'(CAP);
         end else begin
            nb_in = csr_wdata;
         end
         alloc_in = LW'(nb_in);
         valid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nb_ff        <= NB_W'(RST_NB);
         alloc_ff     <= LW'(RST_NB);
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nb_ff        <= nb_in;
         alloc_ff     <= alloc_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      key_ff       <= key_in;
      data_ff      <= data_in;
      blk_ff       <= blk_in;
      pos_ff       <= pos_in;
      scnt_ff      <= scnt_in;
      used_ff      <= used_in;
      link_ff      <= link_in;
      have_free_ff <= have_free_in;
      ins_blk_ff   <= ins_blk_in;
      ins_slot_ff  <= ins_slot_in;
      ins_used_ff  <= ins_used_in;
      ins_link_ff  <= ins_link_in;
      res_st_ff    <= res_st_in;
      res_bidx_ff  <= res_bidx_in;
      res_cpos_ff  <= res_cpos_in;
      res_data_ff  <= res_data_in;
      rsp_st_ff    <= rsp_st_in;
      rsp_bidx_ff  <= rsp_bidx_in;
      rsp_cpos_ff  <= rsp_cpos_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_st_ff;
   assign rsp_block_index    = rsp_bidx_ff;
   assign rsp_chain_position = rsp_cpos_ff;
   assign rsp_found_data     = rsp_data_ff;

   a_alloc_bound: assert property (@(posedge clock) disable iff (reset)
      alloc_ff <= LW'(POOL_BLOCKS))
      else $error("block allocation count beyond pool size");

   a_clear_alloc: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> alloc_ff == LW'(nb_ff))
      else $error("clear did not reset allocation count");

   a_mod_done: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> state_ff == S_MOD)
      else $error("remainder finished outside hashing phase");

   a_resp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("response not presented");

endmodule
